/* hw/rtl/pw_pkg.sv */
// ----------------------------------------------------------------------------
// pw_pkg: shared types, constants and helpers for the perspective warp
// Payload structs, register indexes, FSM encodings and saturation helpers.
// ----------------------------------------------------------------------------
package pw_pkg;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SCALE   = 3'd4;

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WARP = 1'b1;

    // Q15.16 style fixed point word
    typedef logic signed [31:0] fix_t;

    // Register reset values
    localparam logic [8:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [7:0] FRAME_HEIGHT_RST = 8'd128;
    localparam fix_t       COEF_X_RST       = 32'sd0;
    localparam fix_t       COEF_Y_RST       = 32'sd65536;
    localparam fix_t       COEF_SCALE_RST   = 32'sd0;

    typedef struct packed {
        logic       command;
        logic [7:0] column;
        logic [6:0] line;
        logic [7:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         pixel_out;
        logic               inside_res;
        logic signed [15:0] source_x;
        logic signed [15:0] source_y;
    } out_item_t;

    // Row terms handed from the row unit to the top level
    typedef struct packed {
        fix_t run_x;
        fix_t run_step;
        fix_t run_y;
    } row_terms_t;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_ROW,
        CT_ISSUE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        RT_IDLE,
        RT_SCALE,
        RT_NX,
        RT_NY,
        RT_DIVINIT,
        RT_DIV,
        RT_INV,
        RT_MX,
        RT_MX1,
        RT_MY,
        RT_FIN,
        RT_DONE
    } row_state_t;

    // Saturate a 64 bit signed value to 32 bits
    function automatic fix_t sat32(input logic signed [63:0] v);
        fix_t r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Saturate a 32 bit signed value to 16 bits
    function automatic logic signed [15:0] sat16(input fix_t v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/perspective_image_warp.sv */
// ----------------------------------------------------------------------------
// perspective_image_warp: inverse perspective warp of a grayscale frame
// Load requests fill the frame store; warp requests in raster order each
// return one destination pixel with its mapped source point.
//
// Input channel s_*: load (command 0) writes pixel_in at (line, column);
// warp (command 1) maps destination (line, column). Result channel m_*:
// one request per warp, none per load. cfg_*: register writes, always
// ready, to be issued only while the block is idle.
// Loads and warps with column != 0 are accepted back to back while the read
// stage is free. A warp at column 0 first runs the row unit (shared
// multiplier plus a one bit per cycle divider), during which s_ready is low.
// A warp result passes through the read stage and the output register
// (after the row unit for column 0).
// Reset clears the row terms, loads register defaults and empties the
// pipeline; the frame store is not cleared and must be loaded before use.
// A stalled receiver holds the result in the output register; one more warp
// parks in the read stage, after which s_ready drops.
// ----------------------------------------------------------------------------
module perspective_image_warp #(
    parameter int MAX_WIDTH  = pw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pw_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = pw_pkg::FRAC_BITS_DEF,
    parameter int PIXEL_BITS = pw_pkg::PIXEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pw_pkg::in_item_t              s_item,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output pw_pkg::out_item_t             m_item,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pw_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // Configuration registers
    logic [8:0]   frame_width_reg;
    logic [7:0]   frame_height_reg;
    pw_pkg::fix_t coef_x_reg, coef_y_reg, coef_scale_reg;

    // Row state
    pw_pkg::fix_t run_x_reg, run_step_reg, run_y_reg;

    pw_pkg::ctrl_state_t ctrl_reg, ctrl_next;

    // Read stage and output register
    logic               st1_valid_reg;
    logic               st1_inside_reg;
    logic signed [15:0] st1_sx_reg, st1_sy_reg;
    logic               out_valid_reg;
    pw_pkg::out_item_t  out_item_reg;

    logic               accept, out_take, st1_free;
    logic               row_start, warp_issue, load_en;
    logic               row_done;
    pw_pkg::row_terms_t row_terms;

    logic signed [63:0] x_sum;
    pw_pkg::fix_t       new_x, x_floor, y_floor, src_x, src_y;
    logic [31:0]        w_lim, h_lim;
    logic               pt_inside;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [PIXEL_BITS-1:0] rd_data;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= pw_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= pw_pkg::FRAME_HEIGHT_RST;
            coef_x_reg       <= pw_pkg::COEF_X_RST;
            coef_y_reg       <= pw_pkg::COEF_Y_RST;
            coef_scale_reg   <= pw_pkg::COEF_SCALE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                pw_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[8:0];
                pw_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[7:0];
                pw_pkg::CFG_COEF_X:       coef_x_reg       <= cfg_data;
                pw_pkg::CFG_COEF_Y:       coef_y_reg       <= cfg_data;
                pw_pkg::CFG_COEF_SCALE:   coef_scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Step x, truncate both coordinates toward zero, test against the frame
    assign x_sum   = 64'(run_x_reg) + 64'(run_step_reg);
    assign new_x   = pw_pkg::sat32(x_sum);
    assign x_floor = new_x >>> FRAC_BITS;
    assign y_floor = run_y_reg >>> FRAC_BITS;
    assign src_x   = (new_x[31] && new_x[FRAC_BITS-1:0] != '0) ? x_floor + 32'sd1 : x_floor;
    assign src_y   = (run_y_reg[31] && run_y_reg[FRAC_BITS-1:0] != '0) ?
                     y_floor + 32'sd1 : y_floor;

    assign w_lim = (32'(frame_width_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH)
                                                            : 32'(frame_width_reg);
    assign h_lim = (32'(frame_height_reg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT)
                                                              : 32'(frame_height_reg);
    assign pt_inside = !src_x[31] && ($unsigned(src_x) < w_lim) &&
                       !src_y[31] && ($unsigned(src_y) < h_lim);

    assign rd_addr = ADDR_W'(src_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(src_x);
    assign wr_addr = ADDR_W'(s_item.line) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s_item.column);

    // Handshake and control
    assign out_take = !out_valid_reg || m_ready;
    assign st1_free = !st1_valid_reg || out_take;

    always_comb begin
        ctrl_next  = ctrl_reg;
        s_ready    = 1'b0;
        warp_issue = 1'b0;
        row_start  = 1'b0;
        load_en    = 1'b0;
        accept     = 1'b0;
        case (ctrl_reg)
            pw_pkg::CT_IDLE: begin
                s_ready = st1_free;
                accept  = s_valid && st1_free;
                if (accept && s_item.command == pw_pkg::CMD_WARP) begin
                    if (s_item.column == 8'd0) begin
                        row_start = 1'b1;
                        ctrl_next = pw_pkg::CT_ROW;
                    end else begin
                        warp_issue = 1'b1;
                    end
                end
                load_en = accept && s_item.command == pw_pkg::CMD_LOAD &&
                          (32'(s_item.column) < 32'(MAX_WIDTH)) &&
                          (32'(s_item.line) < 32'(MAX_HEIGHT));
            end
            pw_pkg::CT_ROW: begin
                if (row_done) ctrl_next = pw_pkg::CT_ISSUE;
            end
            pw_pkg::CT_ISSUE: begin
                if (st1_free) begin
                    warp_issue = 1'b1;
                    ctrl_next  = pw_pkg::CT_IDLE;
                end
            end
            default: ctrl_next = pw_pkg::CT_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= pw_pkg::CT_IDLE;
        end else begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Row state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_x_reg    <= '0;
            run_step_reg <= '0;
            run_y_reg    <= '0;
        end else if (row_done) begin
            run_x_reg    <= row_terms.run_x;
            run_step_reg <= row_terms.run_step;
            run_y_reg    <= row_terms.run_y;
        end else if (warp_issue) begin
            run_x_reg <= new_x;
        end
    end

    // Valid bits of the read stage and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (warp_issue) begin
                st1_valid_reg <= 1'b1;
            end else if (out_take) begin
                st1_valid_reg <= 1'b0;
            end
            if (out_take) begin
                out_valid_reg <= st1_valid_reg;
            end
        end
    end

    // Payload of the read stage and the output register
    always_ff @(posedge aclk) begin
        if (warp_issue) begin
            st1_inside_reg <= pt_inside;
            st1_sx_reg     <= pw_pkg::sat16(src_x);
            st1_sy_reg     <= pw_pkg::sat16(src_y);
        end
        if (out_take) begin
            out_item_reg.pixel_out  <= st1_inside_reg ? 8'(rd_data) : 8'd0;
            out_item_reg.inside_res <= st1_inside_reg;
            out_item_reg.source_x   <= st1_sx_reg;
            out_item_reg.source_y   <= st1_sy_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    pw_row_terms #(
        .FRAC_BITS (FRAC_BITS)
    ) u_row_terms (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (row_start),
        .row        (s_item.line),
        .coef_x     (coef_x_reg),
        .coef_y     (coef_y_reg),
        .coef_scale (coef_scale_reg),
        .done       (row_done),
        .terms      (row_terms)
    );

    pw_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PIXEL_BITS)
    ) u_frame_store (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (wr_addr),
        .wr_data (PIXEL_BITS'(s_item.pixel_in)),
        .rd_en   (warp_issue && pt_inside),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* hw/rtl/pw_frame_store.sv */
// ----------------------------------------------------------------------------
// pw_frame_store: source frame memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pw_frame_store #(
    parameter int DEPTH  = pw_pkg::MAX_WIDTH_DEF * pw_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = pw_pkg::PIXEL_BITS_DEF
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] frame_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write and registered read; read data holds when no read is requested
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/pw_row_terms.sv */
// ----------------------------------------------------------------------------
// pw_row_terms: per-row projective terms
// Sequencer around one shared 32x32 multiplier and a bit-serial restoring
// divider that forms inv_s = 2^(2*FRAC_BITS) / (scale*row + 1.0).
// ----------------------------------------------------------------------------
module pw_row_terms #(
    parameter int FRAC_BITS = pw_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [6:0]         row,
    input  pw_pkg::fix_t       coef_x,
    input  pw_pkg::fix_t       coef_y,
    input  pw_pkg::fix_t       coef_scale,
    output logic               done,
    output pw_pkg::row_terms_t terms
);

    localparam int Q_W   = 2 * FRAC_BITS + 1;
    localparam int CNT_W = $clog2(Q_W);
    localparam int DEN_W = 41;
    localparam int REM_W = DEN_W + 1;
    localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

    pw_pkg::row_state_t state_reg, state_next;

    logic [6:0]          row_reg;
    logic signed [63:0]  prod_reg;
    logic [DEN_W-1:0]    den_mag_reg;
    logic                den_neg_reg;
    logic                den_zero_reg;
    pw_pkg::fix_t        nx_reg, ny_reg, x1n_reg, inv_reg;
    pw_pkg::fix_t        rx_reg, rx1_reg, ry_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [Q_W-1:0]      q_reg;
    logic [CNT_W-1:0]    cnt_reg;

    pw_pkg::fix_t        mul_a, mul_b, row_ext;
    logic signed [63:0]  mul_full;
    logic signed [63:0]  den_full, den_abs;
    logic [REM_W-1:0]    rem_sh;
    logic                q_bit;
    logic [DEN_W-1:0]    rem_next;
    logic                q_big;
    pw_pkg::fix_t        inv_val;

    assign row_ext = pw_pkg::fix_t'({25'd0, row_reg});

    // Shared multiplier operand select
    always_comb begin
        case (state_reg)
            pw_pkg::RT_SCALE: begin mul_a = coef_scale; mul_b = row_ext; end
            pw_pkg::RT_NX:    begin mul_a = coef_x;     mul_b = row_ext; end
            pw_pkg::RT_NY:    begin mul_a = coef_y;     mul_b = row_ext; end
            pw_pkg::RT_MX:    begin mul_a = nx_reg;     mul_b = inv_reg; end
            pw_pkg::RT_MX1:   begin mul_a = x1n_reg;    mul_b = inv_reg; end
            pw_pkg::RT_MY:    begin mul_a = ny_reg;     mul_b = inv_reg; end
            default:          begin mul_a = coef_scale; mul_b = row_ext; end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Denominator and its magnitude
    assign den_full = prod_reg + ONE64;
    assign den_abs  = den_full[63] ? -den_full : den_full;

    // One restoring divide step; the dividend is a single one at the top bit
    assign rem_sh   = {rem_reg, (cnt_reg == CNT_W'(Q_W - 1))};
    assign q_bit    = (rem_sh >= {1'b0, den_mag_reg});
    assign rem_next = q_bit ? DEN_W'(rem_sh - {1'b0, den_mag_reg}) : rem_sh[DEN_W-1:0];

    // Signed, saturated reciprocal; zero denominator saturates high
    assign q_big = (64'(q_reg) >= 64'h0000_0000_8000_0000);
    always_comb begin
        if (den_zero_reg) begin
            inv_val = 32'sh7FFF_FFFF;
        end else if (!den_neg_reg) begin
            inv_val = q_big ? 32'sh7FFF_FFFF : pw_pkg::fix_t'(32'(q_reg));
        end else begin
            inv_val = q_big ? 32'sh8000_0000 : -pw_pkg::fix_t'(32'(q_reg));
        end
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pw_pkg::RT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pw_pkg::RT_IDLE:    if (start) state_next = pw_pkg::RT_SCALE;
            pw_pkg::RT_SCALE:   state_next = pw_pkg::RT_NX;
            pw_pkg::RT_NX:      state_next = pw_pkg::RT_NY;
            pw_pkg::RT_NY:      state_next = pw_pkg::RT_DIVINIT;
            pw_pkg::RT_DIVINIT: state_next = pw_pkg::RT_DIV;
            pw_pkg::RT_DIV:     if (cnt_reg == '0) state_next = pw_pkg::RT_INV;
            pw_pkg::RT_INV:     state_next = pw_pkg::RT_MX;
            pw_pkg::RT_MX:      state_next = pw_pkg::RT_MX1;
            pw_pkg::RT_MX1:     state_next = pw_pkg::RT_MY;
            pw_pkg::RT_MY:      state_next = pw_pkg::RT_FIN;
            pw_pkg::RT_FIN:     state_next = pw_pkg::RT_DONE;
            pw_pkg::RT_DONE:    state_next = pw_pkg::RT_IDLE;
            default:            state_next = pw_pkg::RT_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (start && state_reg == pw_pkg::RT_IDLE) begin
            row_reg <= row;
        end
        prod_reg <= mul_full;
        case (state_reg)
            pw_pkg::RT_NX: begin
                den_neg_reg  <= den_full[63];
                den_zero_reg <= (den_full == 64'sd0);
                den_mag_reg  <= DEN_W'(den_abs);
            end
            pw_pkg::RT_NY: begin
                nx_reg <= pw_pkg::sat32(prod_reg);
            end
            pw_pkg::RT_DIVINIT: begin
                ny_reg  <= pw_pkg::sat32(prod_reg);
                x1n_reg <= pw_pkg::sat32(64'(nx_reg) + ONE64);
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= CNT_W'(Q_W - 1);
            end
            pw_pkg::RT_DIV: begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[Q_W-2:0], q_bit};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            pw_pkg::RT_INV: begin
                inv_reg <= inv_val;
            end
            // products are floor-shifted back to the fixed point scale
            pw_pkg::RT_MX1: rx_reg  <= pw_pkg::sat32(prod_reg >>> FRAC_BITS);
            pw_pkg::RT_MY:  rx1_reg <= pw_pkg::sat32(prod_reg >>> FRAC_BITS);
            pw_pkg::RT_FIN: ry_reg  <= pw_pkg::sat32(prod_reg >>> FRAC_BITS);
            default: ;
        endcase
    end

    assign done           = (state_reg == pw_pkg::RT_DONE);
    assign terms.run_x    = rx_reg;
    assign terms.run_step = pw_pkg::sat32(64'(rx1_reg) - 64'(rx_reg));
    assign terms.run_y    = ry_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the perspective image warp
// Loads source pixels, then sends warp requests row by row under several
// register settings. A predictor rebuilds the row terms and the mapped point
// in fixed point for every accepted warp request. Each result request is compared
// field by field with the oldest pending prediction. Random gaps are placed on
// both channels, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     CLK_PERIOD     = 4;
    localparam int     TIMEOUT_CYCLES = 1_000_000;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     ITEM_TARGET    = 400;
    localparam int     STORE_DEPTH    = pw_pkg::MAX_WIDTH_DEF * pw_pkg::MAX_HEIGHT_DEF;
    localparam int     FIX_ONE        = 1 << pw_pkg::FRAC_BITS_DEF;
    localparam longint FULL_SCALE     = longint'(1) << (2 * pw_pkg::FRAC_BITS_DEF);
    // index past the register list, must leave every setting unchanged
    localparam logic [pw_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    typedef struct packed {
        logic [8:0]   width;
        logic [7:0]   height;
        pw_pkg::fix_t cx;
        pw_pkg::fix_t cy;
        pw_pkg::fix_t cs;
    } warp_cfg_t;

    typedef struct packed {
        pw_pkg::row_terms_t terms;
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic               hit;
    } mapped_t;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    pw_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    pw_pkg::out_item_t m_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    pw_pkg::in_item_t  pending_q[$];
    pw_pkg::out_item_t expected_q[$];

    // generator side view: mapped points and written store entries
    warp_cfg_t          gen_cfg;
    pw_pkg::row_terms_t gen_terms = '0;
    bit                 loaded [0:STORE_DEPTH-1];
    int                 items_queued = 0;

    // checker side view, advanced on accepted requests
    warp_cfg_t          pred_cfg;
    pw_pkg::row_terms_t pred_terms = '0;
    logic [7:0]         pixel_mem [0:STORE_DEPTH-1];

    int mismatch_count = 0;
    bit send_idle_on   = 1'b0;
    bit recv_idle_on   = 1'b0;
    int hold_req       = 0;

    perspective_image_warp i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Fixed point predictor
    // ------------------------------------------------------------------
    function automatic pw_pkg::fix_t sat_word(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return pw_pkg::fix_t'(v);
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // numerator times reciprocal, floor-shifted back to Q15.16
    function automatic pw_pkg::fix_t scaled(input longint num, input longint inv);
        return sat_word((num * inv) >>> pw_pkg::FRAC_BITS_DEF);
    endfunction

    // row terms formed at column 0 of a destination row
    function automatic pw_pkg::row_terms_t row_start(input warp_cfg_t c,
                                                     input logic [6:0] row);
        pw_pkg::row_terms_t t;
        longint             den, inv, nx, ny;
        pw_pkg::fix_t       x1;
        den = longint'(c.cs) * longint'(row) + FIX_ONE;
        if (den == 0) begin
            inv = 64'sh7FFF_FFFF;
        end else begin
            inv = sat_word(FULL_SCALE / den);
        end
        nx = sat_word(longint'(c.cx) * longint'(row));
        ny = sat_word(longint'(c.cy) * longint'(row));
        t.run_x    = scaled(nx, inv);
        x1         = scaled(sat_word(nx + FIX_ONE), inv);
        t.run_step = sat_word(longint'(x1) - longint'(t.run_x));
        t.run_y    = scaled(ny, inv);
        return t;
    endfunction

    // advance the running x and map one warp request to its source point
    function automatic mapped_t map_point(input pw_pkg::row_terms_t rt, input warp_cfg_t c,
                                          input pw_pkg::in_item_t it);
        mapped_t m;
        int      w, h;
        m.terms = (it.column == 0) ? row_start(c, it.line) : rt;
        m.terms.run_x = sat_word(longint'(m.terms.run_x) + longint'(m.terms.run_step));
        m.src_x = m.terms.run_x / FIX_ONE;
        m.src_y = m.terms.run_y / FIX_ONE;
        w = (c.width > pw_pkg::MAX_WIDTH_DEF) ? pw_pkg::MAX_WIDTH_DEF : int'(c.width);
        h = (c.height > pw_pkg::MAX_HEIGHT_DEF) ? pw_pkg::MAX_HEIGHT_DEF : int'(c.height);
        m.hit = (m.src_x >= 0) && (m.src_x < w) && (m.src_y >= 0) && (m.src_y < h);
        return m;
    endfunction

    function automatic warp_cfg_t apply_reg(input warp_cfg_t c,
                                            input logic [pw_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [31:0] data);
        warp_cfg_t n;
        n = c;
        case (idx)
            pw_pkg::CFG_FRAME_WIDTH: begin
                n.width = data[8:0];
            end
            pw_pkg::CFG_FRAME_HEIGHT: begin
                n.height = data[7:0];
            end
            pw_pkg::CFG_COEF_X: begin
                n.cx = data;
            end
            pw_pkg::CFG_COEF_Y: begin
                n.cy = data;
            end
            pw_pkg::CFG_COEF_SCALE: begin
                n.cs = data;
            end
            default: begin
            end
        endcase
        return n;
    endfunction

    function automatic warp_cfg_t make_cfg(input logic [8:0] w, input logic [7:0] h,
                                           input pw_pkg::fix_t cx, input pw_pkg::fix_t cy,
                                           input pw_pkg::fix_t cs);
        warp_cfg_t c;
        c.width  = w;
        c.height = h;
        c.cx     = cx;
        c.cy     = cy;
        c.cs     = cs;
        return c;
    endfunction

    function automatic pw_pkg::fix_t pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'sh0001_0000;
            default: return -32'sh0001_0000;
        endcase
    endfunction

    function automatic warp_cfg_t pick_cfg();
        warp_cfg_t c;
        int        kind;
        case ($urandom_range(0, 9))
            0: c.width = 9'd1;
            1: c.width = 9'd256;
            2: c.width = 9'd0;
            3: c.width = 9'($urandom_range(0, 511));
            default: c.width = 9'($urandom_range(1, 256));
        endcase
        case ($urandom_range(0, 9))
            0: c.height = 8'd1;
            1: c.height = 8'd128;
            2: c.height = 8'd0;
            3: c.height = 8'($urandom_range(0, 255));
            default: c.height = 8'($urandom_range(1, 128));
        endcase
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            // mild perspective that keeps many points inside the frame
            c.cx = $urandom_range(0, 262144) - 131072;
            c.cy = $urandom_range(16384, 98304);
            c.cs = $urandom_range(0, 1536) - 512;
        end else if (kind < 8) begin
            c.cx = $urandom;
            c.cy = $urandom;
            c.cs = $urandom;
        end else begin
            c.cx = pick_extreme();
            c.cy = pick_extreme();
            c.cs = pick_extreme();
        end
        return c;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    task automatic queue_load(input logic [7:0] col, input logic [6:0] row,
                              input logic [7:0] pix);
        pw_pkg::in_item_t it;
        it.command  = pw_pkg::CMD_LOAD;
        it.column   = col;
        it.line     = row;
        it.pixel_in = pix;
        pending_q.push_back(it);
        loaded[{row, col}] = 1'b1;
        items_queued++;
    endtask

    // a warp that would read an unwritten entry gets a load of it first
    task automatic queue_warp(input logic [7:0] col, input logic [6:0] row);
        pw_pkg::in_item_t it;
        mapped_t          m;
        it.command  = pw_pkg::CMD_WARP;
        it.column   = col;
        it.line     = row;
        it.pixel_in = 8'($urandom_range(0, 255));
        m = map_point(gen_terms, gen_cfg, it);
        if (m.hit && !loaded[{m.src_y[6:0], m.src_x[7:0]}]) begin
            queue_load(m.src_x[7:0], m.src_y[6:0], 8'($urandom_range(0, 255)));
        end
        gen_terms = m.terms;
        pending_q.push_back(it);
        items_queued++;
    endtask

    // one raster row from column 0, with stray loads mixed in
    task automatic queue_row(input logic [6:0] row, input int len);
        for (int col = 0; col < len; col++) begin
            if (items_queued >= ITEM_TARGET) begin
                break;
            end
            if ($urandom_range(0, 99) < 15) begin
                queue_load(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                           8'($urandom_range(0, 255)));
            end
            queue_warp(8'(col), row);
        end
    endtask

    task automatic write_reg(input logic [pw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_cfg = apply_reg(gen_cfg, idx, data);
    endtask

    // upper bits of the frame size words are junk the block must drop
    task automatic write_all(input warp_cfg_t c);
        write_reg(pw_pkg::CFG_FRAME_WIDTH, ($urandom & ~32'h1FF) | 32'(c.width));
        write_reg(pw_pkg::CFG_FRAME_HEIGHT, ($urandom & ~32'hFF) | 32'(c.height));
        write_reg(pw_pkg::CFG_COEF_X, c.cx);
        write_reg(pw_pkg::CFG_COEF_Y, c.cy);
        write_reg(pw_pkg::CFG_COEF_SCALE, c.cs);
    endtask

    // wait until every request is in and every result is out, then let a
    // trailing load finish before the registers change; sampled mid-cycle so
    // the edge activity of driver and monitor has settled
    task automatic drain();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_item   <= '0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pending_q.size() != 0) begin
                s_valid  <= 1'b1;
                s_item   <= pending_q.pop_front();
                send_gap <= send_idle_on ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls and the long hold-off
    // ------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            stall_left <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (recv_idle_on && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict from accepted requests
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        pw_pkg::out_item_t want;
        mapped_t           m;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: %p", m_item));
                end else begin
                    want = expected_q.pop_front();
                    if (m_item.pixel_out !== want.pixel_out) begin
                        report_mismatch($sformatf("pixel_out %0h, want %0h",
                                                  m_item.pixel_out, want.pixel_out));
                    end
                    if (m_item.inside_res !== want.inside_res) begin
                        report_mismatch($sformatf("inside_res %0b, want %0b",
                                                  m_item.inside_res, want.inside_res));
                    end
                    if (m_item.source_x !== want.source_x) begin
                        report_mismatch($sformatf("source_x %0d, want %0d",
                                                  m_item.source_x, want.source_x));
                    end
                    if (m_item.source_y !== want.source_y) begin
                        report_mismatch($sformatf("source_y %0d, want %0d",
                                                  m_item.source_y, want.source_y));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                pred_cfg = apply_reg(pred_cfg, cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                if (s_item.command == pw_pkg::CMD_LOAD) begin
                    pixel_mem[{s_item.line, s_item.column}] = s_item.pixel_in;
                end else begin
                    m = map_point(pred_terms, pred_cfg, s_item);
                    pred_terms      = m.terms;
                    want.pixel_out  = m.hit ? pixel_mem[{m.src_y[6:0], m.src_x[7:0]}] : 8'd0;
                    want.inside_res = m.hit;
                    want.source_x   = clamp16(m.src_x);
                    want.source_y   = clamp16(m.src_y);
                    expected_q.push_back(want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int   phase;
        int   rows;
        int   len;
        int   pick;
        logic [6:0] row;
        gen_cfg  = make_cfg(pw_pkg::FRAME_WIDTH_RST, pw_pkg::FRAME_HEIGHT_RST,
                            pw_pkg::COEF_X_RST, pw_pkg::COEF_Y_RST,
                            pw_pkg::COEF_SCALE_RST);
        pred_cfg = gen_cfg;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, no idling: extreme loads, a warp on the held
        // (zero) row terms, then rows at both ends of the frame
        queue_load(8'd0, 7'd0, 8'h00);
        queue_load(8'd255, 7'd127, 8'hFF);
        queue_warp(8'd7, 7'd100);
        queue_warp(8'd0, 7'd127);
        queue_warp(8'd1, 7'd127);
        queue_warp(8'd0, 7'd0);
        queue_warp(8'd255, 7'd0);
        drain();

        // zero denominator at row 1, negative one at row 2
        write_all(make_cfg(9'd256, 8'd128, 32'sh0001_0000, 32'sh0001_0000,
                           -32'sh0001_0000));
        queue_warp(8'd0, 7'd1);
        queue_warp(8'd1, 7'd1);
        queue_warp(8'd0, 7'd2);
        queue_warp(8'd3, 7'd2);
        drain();

        // oversized frame registers, saturating coefficients
        write_reg(CFG_UNUSED, $urandom);
        write_all(make_cfg(9'd511, 8'd255, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0));
        queue_warp(8'd0, 7'd127);
        queue_warp(8'd0, 7'd64);
        drain();

        // empty frame: no point can be inside
        write_all(make_cfg(9'd0, 8'd0, 32'sh0, 32'sh0001_0000, 32'sh0));
        queue_warp(8'd0, 7'd3);
        queue_warp(8'd1, 7'd3);
        drain();

        // random settings, mostly well-formed rows with some noise
        phase = 0;
        while (items_queued < ITEM_TARGET) begin
            write_all(pick_cfg());
            if (phase == 0) begin
                // receiver holds off while the sender keeps offering a row
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
                queue_row(7'($urandom_range(0, 127)), 48);
                hold_req++;
            end else begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
                rows = $urandom_range(3, 8);
                for (int r = 0; r < rows; r++) begin
                    if (items_queued >= ITEM_TARGET) begin
                        break;
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 10) begin
                        for (int n = 0; n < 4; n++) begin
                            if ($urandom_range(0, 1) == 1) begin
                                queue_warp(8'($urandom_range(0, 255)),
                                           7'($urandom_range(0, 127)));
                            end else begin
                                queue_load(8'($urandom_range(0, 255)),
                                           7'($urandom_range(0, 127)),
                                           8'($urandom_range(0, 255)));
                            end
                        end
                    end else begin
                        if (pick < 20) begin
                            row = 7'd127;
                        end else if (pick < 30) begin
                            row = 7'd0;
                        end else begin
                            row = 7'($urandom_range(0, 127));
                        end
                        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20)
                                                           : $urandom_range(21, 80);
                        queue_row(row, len);
                    end
                end
            end
            drain();
            phase++;
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
